>>> rtl/core/conv_window_address_gen_assert.svh
// Assertion macros for the convolution window address generator.
`ifndef CONV_WINDOW_ADDRESS_GEN_ASSERT_SVH
`define CONV_WINDOW_ADDRESS_GEN_ASSERT_SVH
`ifndef SYNTH
`define CWAG_ASSERT_IMPLY(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("cwag assertion failed");
`define CWAG_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("cwag assertion failed");
`else
`define CWAG_ASSERT_IMPLY(name, cond, expr)
`define CWAG_ASSERT_NEXT(name, cond, expr)
`endif
`endif

>>> rtl/core/cwag_pkg.sv
// Shared types and constants of the convolution window address generator.
`timescale 1ns / 1ps
package cwag_pkg;

  localparam int ADDR_W = 48;
  localparam int SLOT_W = 6;
  localparam int MAX_RESULTS = 64;
  localparam int OFF_W = 8;
  localparam int STEP_W = 29;
  localparam int PROD_W = OFF_W + STEP_W;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam logic [1:0] REG_ELEMENT_BYTES = 2'd0;
  localparam logic [1:0] REG_ROW_PITCH     = 2'd1;
  localparam logic [1:0] REG_COL_PITCH     = 2'd2;
  localparam logic [1:0] REG_PAD_ADDRESS   = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [OFF_W-1:0]  row_off;
    logic [OFF_W-1:0]  col_off;
    logic              pad;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } point_t;

endpackage

>>> rtl/core/cwag_seq.sv
// Request register and point sequencer that walks output and kernel positions.
`timescale 1ns / 1ps
module cwag_seq #(
  parameter int OUT_ROWS   = 2,
  parameter int OUT_COLS   = 2,
  parameter int KER_ROWS   = 3,
  parameter int KER_COLS   = 3,
  parameter int ROW_STRIDE = 1,
  parameter int COL_STRIDE = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [cwag_pkg::ADDR_W-1:0] base_address,
  input  logic [7:0]                 pad_top,
  input  logic [7:0]                 win_rows,
  input  logic [7:0]                 left_pad,
  input  logic [7:0]                 win_cols,
  output logic                       pt_valid,
  input  logic                       pt_ready,
  output cwag_pkg::point_t           pt
);
  import cwag_pkg::*;

  localparam int OR_W = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
  localparam int OC_W = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
  localparam int KR_W = (KER_ROWS > 1) ? $clog2(KER_ROWS) : 1;
  localparam int KC_W = (KER_COLS > 1) ? $clog2(KER_COLS) : 1;
  localparam int POINTS = OUT_ROWS * OUT_COLS;
  localparam int ALL = POINTS * KER_ROWS * KER_COLS;
  localparam int TOTAL = (ALL > MAX_RESULTS) ? MAX_RESULTS : ALL;
  localparam logic [SLOT_W-1:0] LAST_N = SLOT_W'(TOTAL - 1);
  localparam logic [OR_W-1:0] OI_LAST = OR_W'(OUT_ROWS - 1);
  localparam logic [OC_W-1:0] OJ_LAST = OC_W'(OUT_COLS - 1);
  localparam logic [KR_W-1:0] KI_LAST = KR_W'(KER_ROWS - 1);
  localparam logic [KC_W-1:0] KJ_LAST = KC_W'(KER_COLS - 1);

  logic              busy;
  logic [ADDR_W-1:0] base;
  logic [7:0]        ptop;
  logic [7:0]        pleft;
  logic [8:0]        row_end;
  logic [8:0]        col_end;
  logic [OR_W-1:0]   oi;
  logic [OC_W-1:0]   oj;
  logic [KR_W-1:0]   ki;
  logic [KC_W-1:0]   kj;
  logic [SLOT_W-1:0] n;

  logic [8:0] ii;
  logic [8:0] ij;
  logic       issue;
  logic       is_last;
  logic       accept;

  assign ii = 9'(int'(oi) * ROW_STRIDE + int'(ki));
  assign ij = 9'(int'(oj) * COL_STRIDE + int'(kj));
  assign is_last = (n == LAST_N);
  assign issue = busy && pt_ready;
  assign req_ready = !busy || (pt_ready && is_last);
  assign accept = req_valid && req_ready;

  assign pt_valid = busy;
  assign pt.base = base;
  assign pt.row_off = OFF_W'(ii - {1'b0, ptop});
  assign pt.col_off = OFF_W'(ij - {1'b0, pleft});
  assign pt.pad = (ii < {1'b0, ptop}) || (ii >= row_end) ||
                  (ij < {1'b0, pleft}) || (ij >= col_end);
  assign pt.last = is_last;
  assign pt.slot = SLOT_W'((int'(ki) * KER_COLS + int'(kj)) * POINTS +
                           int'(oi) * OUT_COLS + int'(oj));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (issue && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= base_address;
      ptop <= pad_top;
      pleft <= left_pad;
      row_end <= {1'b0, pad_top} + {1'b0, win_rows};
      col_end <= {1'b0, left_pad} + {1'b0, win_cols};
      oi <= '0;
      oj <= '0;
      ki <= '0;
      kj <= '0;
      n <= '0;
    end else if (issue) begin
      n <= n + 1'b1;
      if (kj == KJ_LAST) begin
        kj <= '0;
        if (ki == KI_LAST) begin
          ki <= '0;
          if (oj == OJ_LAST) begin
            oj <= '0;
            oi <= (oi == OI_LAST) ? '0 : oi + 1'b1;
          end else begin
            oj <= oj + 1'b1;
          end
        end else begin
          ki <= ki + 1'b1;
        end
      end else begin
        kj <= kj + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/cwag_addr_pipe.sv
// Four-stage address pipeline: point register, row product, column product, final sum.
`timescale 1ns / 1ps
module cwag_addr_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  cwag_pkg::point_t              pt,
  input  logic [cwag_pkg::STEP_W-1:0]   row_step,
  input  logic [cwag_pkg::STEP_W-1:0]   col_step,
  input  logic [cwag_pkg::ADDR_W-1:0]   pad_address,
  output logic                          ptr_valid,
  input  logic                          ptr_ready,
  output logic [cwag_pkg::SLOT_W-1:0]   slot_index,
  output logic [cwag_pkg::ADDR_W-1:0]   pointer,
  output logic                          is_pad,
  output logic                          last
);
  import cwag_pkg::*;

  logic a1, a2, a3, a4;

  logic   v1;
  point_t p1;

  logic              v2;
  logic [ADDR_W-1:0] base2;
  logic [OFF_W-1:0]  col_off2;
  logic [PROD_W-1:0] rprod2;
  logic              pad2;
  logic              last2;
  logic [SLOT_W-1:0] slot2;

  logic              v3;
  logic [ADDR_W-1:0] sum3;
  logic [PROD_W-1:0] cprod3;
  logic              pad3;
  logic              last3;
  logic [SLOT_W-1:0] slot3;

  logic [PROD_W-1:0] rprod_next;
  logic [PROD_W-1:0] cprod_next;

  assign a4 = !ptr_valid || ptr_ready;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign pt_ready = a1;

  assign rprod_next = p1.row_off * row_step;
  assign cprod_next = col_off2 * col_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ptr_valid <= 1'b0;
    end else begin
      if (a1) begin
        v1 <= pt_valid;
      end
      if (a2) begin
        v2 <= v1;
      end
      if (a3) begin
        v3 <= v2;
      end
      if (a4) begin
        ptr_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a1) begin
      p1 <= pt;
    end
    if (a2) begin
      base2 <= p1.base;
      col_off2 <= p1.col_off;
      rprod2 <= rprod_next;
      pad2 <= p1.pad;
      last2 <= p1.last;
      slot2 <= p1.slot;
    end
    if (a3) begin
      sum3 <= base2 + ADDR_W'(rprod2);
      cprod3 <= cprod_next;
      pad3 <= pad2;
      last3 <= last2;
      slot3 <= slot2;
    end
    if (a4) begin
      pointer <= pad3 ? pad_address : sum3 + ADDR_W'(cprod3);
      is_pad <= pad3;
      last <= last3;
      slot_index <= slot3;
    end
  end

endmodule

>>> rtl/core/conv_window_address_gen.sv
// Top level of the convolution window address generator with its register port.
//
// One tile request produces OUT_ROWS*OUT_COLS*KER_ROWS*KER_COLS pointers (at most 64),
// one per cycle unless the output stalls; the point sequencer issues one kernel point per
// cycle while pt_ready is high. The next request is taken in the cycle its predecessor
// issues its final point, so tiles stream without gaps. Each pointer passes the point
// register, row product, column product and final sum stages. Registers sit at byte
// addresses 0, 8, 16 and 24 (element_bytes, row_pitch, col_pitch, pad_address); the user
// must write them only while no transfer is in flight, which the block does not enforce.
`timescale 1ns / 1ps
`include "conv_window_address_gen_assert.svh"
module conv_window_address_gen #(
  parameter int OUT_ROWS   = 2,
  parameter int OUT_COLS   = 2,
  parameter int KER_ROWS   = 3,
  parameter int KER_COLS   = 3,
  parameter int ROW_STRIDE = 1,
  parameter int COL_STRIDE = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cwag_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cwag_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cwag_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [cwag_pkg::ADDR_W-1:0]       base_address,
  input  logic [7:0]                        pad_top,
  input  logic [7:0]                        win_rows,
  input  logic [7:0]                        left_pad,
  input  logic [7:0]                        win_cols,
  output logic                              ptr_valid,
  input  logic                              ptr_ready,
  output logic [cwag_pkg::SLOT_W-1:0]       slot_index,
  output logic [cwag_pkg::ADDR_W-1:0]       pointer,
  output logic                              is_pad,
  output logic                              last
);
  import cwag_pkg::*;

  logic [4:0]        element_bytes;
  logic [23:0]       row_pitch;
  logic [23:0]       col_pitch;
  logic [ADDR_W-1:0] pad_address;
  logic [STEP_W-1:0] row_step;
  logic [STEP_W-1:0] col_step;
  logic              wr_en;
  logic [1:0]        reg_index;

  logic   pt_valid;
  logic   pt_ready;
  point_t pt;

  assign pready = 1'b1;
  assign reg_index = paddr[4:3];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= 5'd1;
      row_pitch <= '0;
      col_pitch <= '0;
      pad_address <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_ELEMENT_BYTES: element_bytes <= pwdata[4:0];
        REG_ROW_PITCH:     row_pitch <= pwdata[23:0];
        REG_COL_PITCH:     col_pitch <= pwdata[23:0];
        REG_PAD_ADDRESS:   pad_address <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_step <= '0;
      col_step <= '0;
    end else begin
      row_step <= row_pitch * element_bytes;
      col_step <= col_pitch * element_bytes;
    end
  end

  always_comb begin
    case (reg_index)
      REG_ELEMENT_BYTES: prdata = APB_DATA_W'(element_bytes);
      REG_ROW_PITCH:     prdata = APB_DATA_W'(row_pitch);
      REG_COL_PITCH:     prdata = APB_DATA_W'(col_pitch);
      REG_PAD_ADDRESS:   prdata = APB_DATA_W'(pad_address);
      default:           prdata = '0;
    endcase
  end

  cwag_seq #(
    .OUT_ROWS   (OUT_ROWS),
    .OUT_COLS   (OUT_COLS),
    .KER_ROWS   (KER_ROWS),
    .KER_COLS   (KER_COLS),
    .ROW_STRIDE (ROW_STRIDE),
    .COL_STRIDE (COL_STRIDE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .base_address (base_address),
    .pad_top      (pad_top),
    .win_rows     (win_rows),
    .left_pad     (left_pad),
    .win_cols     (win_cols),
    .pt_valid     (pt_valid),
    .pt_ready     (pt_ready),
    .pt           (pt)
  );

  cwag_addr_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt          (pt),
    .row_step    (row_step),
    .col_step    (col_step),
    .pad_address (pad_address),
    .ptr_valid   (ptr_valid),
    .ptr_ready   (ptr_ready),
    .slot_index  (slot_index),
    .pointer     (pointer),
    .is_pad      (is_pad),
    .last        (last)
  );

  `CWAG_ASSERT_IMPLY(a_pad_pointer, ptr_valid && is_pad, pointer == pad_address)
  `CWAG_ASSERT_IMPLY(a_last_frees_request, pt_valid && pt_ready && pt.last, req_ready)
  `CWAG_ASSERT_NEXT(a_points_continue, pt_valid && pt_ready && !pt.last, pt_valid)

endmodule
